/* rtl/core/jcs_pkg.sv */
// shared types and constants for the jsonc comment stripper
// no dependencies; used by every module in rtl/core
package jcs_pkg;

  localparam int unsigned FifoDepth = 2;

  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBsl   = 8'h5C;

  typedef enum logic [6:0] {
    ModeNormal = 7'b0000001,
    ModeSlash  = 7'b0000010,
    ModeLine   = 7'b0000100,
    ModeBlock  = 7'b0001000,
    ModeBstar  = 7'b0010000,
    ModeStr    = 7'b0100000,
    ModeEsc    = 7'b1000000
  } scan_mode_e;

  // one queued command: one or two output transfers
  typedef struct packed {
    logic       two;       // two transfers: data0 then data1
    logic       has_byte;  // single transfer carries a byte
    logic [7:0] data0;
    logic [7:0] data1;
    logic       last;
  } cmd_t;

endpackage

/* rtl/core/jcs_front.sv */
// front end: accepts input bytes, runs the scan mode machine, queues commands
// depends on jcs_pkg
module jcs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // [7:0] in_byte
  input  logic                s_axis_tlast_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output jcs_pkg::cmd_t       q_cmd_o
);

  jcs_pkg::scan_mode_e mode_q, mode_d, next_mode;
  logic       accept;
  logic       pre_slash, emit_c, post_slash;
  logic [1:0] n_res;
  logic [7:0] c;

  assign c               = s_axis_tdata_i;
  assign s_axis_tready_o = !q_full_i;
  assign accept          = s_axis_tvalid_i && !q_full_i;

  always_comb begin
    next_mode = mode_q;
    pre_slash = 1'b0;
    emit_c    = 1'b0;
    case (mode_q)
      jcs_pkg::ModeSlash: begin
        if (c == jcs_pkg::ChSlash) begin
          next_mode = jcs_pkg::ModeLine;
        end else if (c == jcs_pkg::ChStar) begin
          next_mode = jcs_pkg::ModeBlock;
        end else begin
          // held slash goes out ahead of this byte
          pre_slash = 1'b1;
          emit_c    = 1'b1;
          next_mode = (c == jcs_pkg::ChQuote) ? jcs_pkg::ModeStr : jcs_pkg::ModeNormal;
        end
      end
      jcs_pkg::ModeLine: begin
        if (c == jcs_pkg::ChNl) begin
          emit_c    = 1'b1;
          next_mode = jcs_pkg::ModeNormal;
        end
      end
      jcs_pkg::ModeBlock: begin
        if (c == jcs_pkg::ChStar) next_mode = jcs_pkg::ModeBstar;
      end
      jcs_pkg::ModeBstar: begin
        if (c == jcs_pkg::ChSlash) begin
          next_mode = jcs_pkg::ModeNormal;
        end else if (c != jcs_pkg::ChStar) begin
          next_mode = jcs_pkg::ModeBlock;
        end
      end
      jcs_pkg::ModeStr: begin
        emit_c = 1'b1;
        if (c == jcs_pkg::ChBsl) begin
          next_mode = jcs_pkg::ModeEsc;
        end else if (c == jcs_pkg::ChQuote) begin
          next_mode = jcs_pkg::ModeNormal;
        end
      end
      jcs_pkg::ModeEsc: begin
        emit_c    = 1'b1;
        next_mode = jcs_pkg::ModeStr;
      end
      default: begin
        if (c == jcs_pkg::ChSlash) begin
          next_mode = jcs_pkg::ModeSlash;
        end else begin
          emit_c    = 1'b1;
          next_mode = (c == jcs_pkg::ChQuote) ? jcs_pkg::ModeStr : jcs_pkg::ModeNormal;
        end
      end
    endcase
  end

  // a slash still held at end of stream is flushed
  assign post_slash = s_axis_tlast_i && (next_mode == jcs_pkg::ModeSlash);
  assign n_res      = {1'b0, pre_slash} + {1'b0, emit_c} + {1'b0, post_slash};

  always_comb begin
    q_cmd_o.two      = (n_res == 2'd2);
    q_cmd_o.has_byte = (n_res != 2'd0);
    q_cmd_o.last     = s_axis_tlast_i;
    if (pre_slash) begin
      q_cmd_o.data0 = jcs_pkg::ChSlash;
    end else if (emit_c) begin
      q_cmd_o.data0 = c;
    end else if (post_slash) begin
      q_cmd_o.data0 = jcs_pkg::ChSlash;
    end else begin
      q_cmd_o.data0 = 8'h00;
    end
    q_cmd_o.data1 = (pre_slash && emit_c) ? c : jcs_pkg::ChSlash;
  end

  assign q_push_o = accept && ((n_res != 2'd0) || s_axis_tlast_i);

  always_comb begin
    mode_d = mode_q;
    if (accept) begin
      mode_d = s_axis_tlast_i ? jcs_pkg::ModeNormal : next_mode;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jcs_pkg::ModeNormal;
    end else begin
      mode_q <= mode_d;
    end
  end

  a_last_resets_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast_i |=> mode_q == jcs_pkg::ModeNormal)
    else $error("mode not back to normal after last transfer");

  a_last_always_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tlast_i |-> q_push_o)
    else $error("last transfer produced no command");

endmodule

/* rtl/core/jcs_fifo.sv */
// short command queue between front and back end
// depends on jcs_pkg
module jcs_fifo #(
  parameter int unsigned Depth = jcs_pkg::FifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jcs_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output jcs_pkg::cmd_t head_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  jcs_pkg::cmd_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_cmd_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt)
    else $error("queue count overflow");

endmodule

/* rtl/core/jcs_back.sv */
// back end: expands queued commands into output transfers via an output register
// depends on jcs_pkg
module jcs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jcs_pkg::cmd_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  output logic [7:0]    m_axis_tdata_o,  // [7:0] out_byte
  output logic          m_axis_tuser_o,  // [0] has_byte
  output logic          m_axis_tlast_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_data_q, out_data_d;
  logic       out_has_q, out_has_d;
  logic       out_last_q, out_last_d;
  logic       pend_q, pend_d;
  logic [7:0] pend_data_q, pend_data_d;
  logic       pend_last_q, pend_last_d;
  logic       load;

  assign load  = !out_valid_q || m_axis_tready_i;
  assign pop_o = load && !pend_q && !empty_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_has_d   = out_has_q;
    out_last_d  = out_last_q;
    pend_d      = pend_q;
    pend_data_d = pend_data_q;
    pend_last_d = pend_last_q;
    if (load) begin
      if (pend_q) begin
        // second half of a two-transfer command
        out_valid_d = 1'b1;
        out_data_d  = pend_data_q;
        out_has_d   = 1'b1;
        out_last_d  = pend_last_q;
        pend_d      = 1'b0;
      end else if (!empty_i) begin
        out_valid_d = 1'b1;
        out_data_d  = head_i.data0;
        if (head_i.two) begin
          out_has_d   = 1'b1;
          out_last_d  = 1'b0;
          pend_d      = 1'b1;
          pend_data_d = head_i.data1;
          pend_last_d = head_i.last;
        end else begin
          out_has_d  = head_i.has_byte;
          out_last_d = head_i.last;
        end
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_has_q   <= out_has_d;
    out_last_q  <= out_last_d;
    pend_data_q <= pend_data_d;
    pend_last_q <= pend_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_has_q;
  assign m_axis_tlast_o  = out_last_q;

  a_pend_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q && out_has_q && !out_last_q)
    else $error("pending second transfer without its first in the output");

  a_bare_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_has_q |-> out_last_q && out_data_q == 8'h00)
    else $error("byteless transfer not a clean end marker");

endmodule

/* rtl/core/jsonc_comment_stripper_core.sv */
// path: a byte reaches the output through the command queue and then the output register
// throughput: one input transfer per cycle while the queue has room; one output transfer per
//   cycle while the sink is ready; a repaid held slash makes two transfers, absorbed by the queue
// reset: rst_ni asynchronous active low; scan mode back to normal, queue and output emptied
// top level: front end, command queue, back end; depends on jcs_pkg
module jsonc_comment_stripper_core #(
  parameter int unsigned FIFO_DEPTH = jcs_pkg::FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,   // in_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] has_byte
  output logic       m_axis_tlast_o    // out_last
);

  jcs_pkg::cmd_t push_cmd, head_cmd;
  logic          q_full, q_push, q_pop, q_empty;

  jcs_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  jcs_fifo #(
    .Depth (FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .empty_o    (q_empty)
  );

  jcs_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_cmd),
    .empty_i         (q_empty),
    .pop_o           (q_pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule
